/* rtl/bsbc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbc_pkg
// shared types and codes for the byte stream buffer with read/write cursors
// ----------------------------------------------------------------------------
package bsbc_pkg;

    // store depth default
    localparam int BSBC_DEPTH = 256;

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int ORIGIN_W = 2;
    localparam int OFFSET_W = 10;
    localparam int SIZE_W   = 9;
    localparam int CFG_IX_W = 2;
    localparam int CFG_W    = 9;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UNGET = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SEEK  = 2'd3;

    // seek origins
    localparam logic [ORIGIN_W-1:0] ORG_START = 2'd0;
    localparam logic [ORIGIN_W-1:0] ORG_REL   = 2'd1;
    localparam logic [ORIGIN_W-1:0] ORG_END   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IX_W-1:0] CFG_READ_EN  = 2'd0;
    localparam logic [CFG_IX_W-1:0] CFG_WRITE_EN = 2'd1;
    localparam logic [CFG_IX_W-1:0] CFG_BUF_SIZE = 2'd2;

    // sequencer states
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

endpackage

/* rtl/byte_stream_buffer_cursors.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_buffer_cursors
// byte store with separate read and write cursors, put/get/unget/seek requests
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  request   | i_valid / o_stall    | i_req_type i_put_byte i_seek_origin
//            |                      | i_seek_offset
//  result    | o_valid / i_stall    | o_byte_out o_end_hit o_end_flag o_move_refused
//  config    | i_cfg_we             | i_cfg_index i_cfg_wdata
//
//  one request per cycle while o_stall is low; the result appears in the output
//  register the cycle after the request is taken, with get data straight from the
//  store's read register; reset starts a clearing pass that zeroes the store;
//  o_stall is high during the pass (config writes still land)
//  a result held by i_stall holds o_stall high, a result taken frees the slot
//  in the same cycle
// ----------------------------------------------------------------------------
module byte_stream_buffer_cursors #(
    parameter int BUFFER_DEPTH = bsbc_pkg::BSBC_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bsbc_pkg::REQ_W-1:0]     i_req_type,
    input  logic [bsbc_pkg::BYTE_W-1:0]    i_put_byte,
    input  logic [bsbc_pkg::ORIGIN_W-1:0]  i_seek_origin,
    input  logic signed [bsbc_pkg::OFFSET_W-1:0] i_seek_offset,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bsbc_pkg::BYTE_W-1:0]    o_byte_out,
    output logic                           o_end_hit,
    output logic                           o_end_flag,
    output logic                           o_move_refused,
    // config port
    input  logic                           i_cfg_we,
    input  logic [bsbc_pkg::CFG_IX_W-1:0]  i_cfg_index,
    input  logic [bsbc_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import bsbc_pkg::*;

    // address width, cursor width (cursor may sit at DEPTH), size compare width
    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = (CW > SIZE_W) ? CW : SIZE_W;
    // signed width for relative seek arithmetic
    localparam int EW = ((CW > OFFSET_W) ? CW : OFFSET_W) + 2;

    // sequencer
    t_state r_state, n_state;
    logic   w_clearing;
    logic [AW-1:0] r_clr_addr;

    // config registers
    logic              r_cfg_rd;
    logic              r_cfg_wr;
    logic [SIZE_W-1:0] r_cfg_size;

    // cursors and sticky end flag
    logic [CW-1:0] r_rpos, n_rpos;
    logic [CW-1:0] r_rleft, n_rleft;
    logic [CW-1:0] r_wpos, n_wpos;
    logic [CW-1:0] r_wleft, n_wleft;
    logic          r_eos, n_eos;

    // result register
    logic              r_ovld;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_from_mem, n_from_mem;
    logic              r_hit, n_hit;
    logic              r_refused, n_refused;

    // store
    logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [BYTE_W-1:0] w_mem_wdata;
    logic              w_put_store;
    logic              w_get_read;

    logic          w_acc;
    logic [SW-1:0] w_size_raw;
    logic [CW-1:0] w_size;

    // relative seek
    logic signed [EW-1:0] w_off;
    logic signed [EW-1:0] w_size_x;
    logic signed [EW-1:0] w_rnp, w_rnl, w_wnp, w_wnl;
    logic                 w_rok, w_wok;

    function automatic logic fits(input logic signed [EW-1:0] v,
                                  input logic signed [EW-1:0] lim);
        return (v >= 0) && (v <= lim);
    endfunction

    // ---------------- sequencer: clearing pass, then running ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(BUFFER_DEPTH - 1)) n_state = ST_RUN;
            end
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_CLEAR: w_clearing = 1'b1;
            ST_RUN:   w_clearing = 1'b0;
            default:  w_clearing = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (w_clearing) r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // ---------------- handshake ----------------
    // a new request may enter when no clearing pass runs and the result slot is empty or being taken
    assign o_stall = w_clearing || (r_ovld && i_stall);
    assign w_acc   = i_valid && !o_stall;

    // ---------------- config writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rd   <= 1'b1;
            r_cfg_wr   <= 1'b1;
            r_cfg_size <= SIZE_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_READ_EN:  r_cfg_rd   <= i_cfg_wdata[0];
                CFG_WRITE_EN: r_cfg_wr   <= i_cfg_wdata[0];
                CFG_BUF_SIZE: r_cfg_size <= i_cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // size in use, clamped to 1..BUFFER_DEPTH
    always_comb begin
        w_size_raw = SW'(r_cfg_size);
        if (w_size_raw == '0)
            w_size = CW'(1);
        else if (w_size_raw > SW'(BUFFER_DEPTH))
            w_size = CW'(BUFFER_DEPTH);
        else
            w_size = w_size_raw[CW-1:0];
    end

    // ---------------- relative seek range checks ----------------
    always_comb begin
        w_off    = {{(EW-OFFSET_W){i_seek_offset[OFFSET_W-1]}}, i_seek_offset};
        w_size_x = signed'({{(EW-CW){1'b0}}, w_size});
        w_rnp    = signed'({{(EW-CW){1'b0}}, r_rpos})  + w_off;
        w_rnl    = signed'({{(EW-CW){1'b0}}, r_rleft}) - w_off;
        w_wnp    = signed'({{(EW-CW){1'b0}}, r_wpos})  + w_off;
        w_wnl    = signed'({{(EW-CW){1'b0}}, r_wleft}) - w_off;
        w_rok    = !r_cfg_rd || (fits(w_rnp, w_size_x) && fits(w_rnl, w_size_x));
        w_wok    = !r_cfg_wr || (fits(w_wnp, w_size_x) && fits(w_wnl, w_size_x));
    end

    // ---------------- request decode and cursor update ----------------
    always_comb begin
        n_rpos     = r_rpos;
        n_rleft    = r_rleft;
        n_wpos     = r_wpos;
        n_wleft    = r_wleft;
        n_eos      = r_eos;
        n_byte     = '0;
        n_from_mem = 1'b0;
        n_hit      = 1'b0;
        n_refused  = 1'b0;
        w_put_store = 1'b0;
        w_get_read  = 1'b0;
        case (i_req_type)
            REQ_PUT: begin
                if (r_wleft == '0) begin
                    n_eos = 1'b1;
                    n_hit = 1'b1;
                end else begin
                    // a cursor past the store still advances but stores nothing
                    w_put_store = (r_wpos < CW'(BUFFER_DEPTH));
                    n_wpos  = r_wpos + CW'(1);
                    n_wleft = r_wleft - CW'(1);
                    n_byte  = i_put_byte;
                end
            end
            REQ_GET: begin
                if (r_rleft == '0) begin
                    n_eos = 1'b1;
                    n_hit = 1'b1;
                end else begin
                    w_get_read = (r_rpos < CW'(BUFFER_DEPTH));
                    n_from_mem = w_get_read;
                    n_rpos  = r_rpos + CW'(1);
                    n_rleft = r_rleft - CW'(1);
                end
            end
            REQ_UNGET: begin
                if (r_rpos == '0) begin
                    n_refused = 1'b1;
                end else begin
                    if (r_rleft == '0) n_eos = 1'b0;
                    n_rpos  = r_rpos - CW'(1);
                    n_rleft = r_rleft + CW'(1);
                end
            end
            REQ_SEEK: begin
                n_eos = 1'b0;
                case (i_seek_origin)
                    ORG_START: begin
                        if (r_cfg_rd) begin
                            n_rpos  = '0;
                            n_rleft = w_size;
                        end
                        if (r_cfg_wr) begin
                            n_wpos  = '0;
                            n_wleft = w_size;
                        end
                    end
                    ORG_END: begin
                        if (r_cfg_rd) begin
                            n_rpos  = w_size;
                            n_rleft = '0;
                        end
                        if (r_cfg_wr) begin
                            n_wpos  = w_size;
                            n_wleft = '0;
                        end
                    end
                    ORG_REL: begin
                        // all enabled cursors move, or none
                        if (!(w_rok && w_wok)) begin
                            n_refused = 1'b1;
                        end else begin
                            if (r_cfg_rd) begin
                                n_rpos  = w_rnp[CW-1:0];
                                n_rleft = w_rnl[CW-1:0];
                            end
                            if (r_cfg_wr) begin
                                n_wpos  = w_wnp[CW-1:0];
                                n_wleft = w_wnl[CW-1:0];
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpos  <= '0;
            r_rleft <= '0;
            r_wpos  <= '0;
            r_wleft <= '0;
            r_eos   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_rpos  <= n_rpos;
                r_rleft <= n_rleft;
                r_wpos  <= n_wpos;
                r_wleft <= n_wleft;
                r_eos   <= n_eos;
                r_ovld  <= 1'b1;
            end else if (!i_stall) begin
                r_ovld  <= 1'b0;
            end
        end
    end

    // result payload, loaded with the request
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_byte     <= n_byte;
            r_from_mem <= n_from_mem;
            r_hit      <= n_hit;
            r_refused  <= n_refused;
        end
    end

    // ---------------- byte store ----------------
    // the clearing pass owns the write port; a put writes at its accept edge,
    // so a later get always reads the stored value
    always_comb begin
        if (w_clearing) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr_addr;
            w_mem_wdata = '0;
        end else begin
            w_mem_we    = w_acc && w_put_store;
            w_mem_waddr = r_wpos[AW-1:0];
            w_mem_wdata = i_put_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) mem[w_mem_waddr] <= w_mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_get_read) r_rdata <= mem[r_rpos[AW-1:0]];
    end

    // ---------------- outputs ----------------
    assign o_valid        = r_ovld;
    assign o_byte_out     = r_from_mem ? r_rdata : r_byte;
    assign o_end_hit      = r_hit;
    assign o_end_flag     = r_eos;
    assign o_move_refused = r_refused;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the byte stream buffer with read and write cursors;
// a cycle-free model of the store and both cursors predicts every response,
// directed tests cover power-up, put/get round trips and seek limits, then
// random traffic runs under several cursor enable and buffer size settings
// with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module tb;
    import bsbc_pkg::*;

    localparam int DEPTH = BSBC_DEPTH;
    // seek origin that has no meaning, still clears the end flag
    localparam logic [ORIGIN_W-1:0] ORG_NONE = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              end_hit;
        logic              end_flag;
        logic              move_refused;
    } stream_resp_t;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_valid        = 1'b0;
    logic                       o_stall;
    logic [REQ_W-1:0]           i_req_type     = REQ_PUT;
    logic [BYTE_W-1:0]          i_put_byte     = '0;
    logic [ORIGIN_W-1:0]        i_seek_origin  = ORG_START;
    logic signed [OFFSET_W-1:0] i_seek_offset  = '0;
    logic                       o_valid;
    logic                       i_stall        = 1'b0;
    logic [BYTE_W-1:0]          o_byte_out;
    logic                       o_end_hit;
    logic                       o_end_flag;
    logic                       o_move_refused;
    logic                       i_cfg_we       = 1'b0;
    logic [CFG_IX_W-1:0]        i_cfg_index    = CFG_READ_EN;
    logic [CFG_W-1:0]           i_cfg_wdata    = '0;

    byte_stream_buffer_cursors u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_put_byte     (i_put_byte),
        .i_seek_origin  (i_seek_origin),
        .i_seek_offset  (i_seek_offset),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_byte_out     (o_byte_out),
        .o_end_hit      (o_end_hit),
        .o_end_flag     (o_end_flag),
        .o_move_refused (o_move_refused),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // stream model: store, both cursors, sticky end flag, configuration
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] store_copy [DEPTH];
    int                rd_pos;
    int                rd_left;
    int                wr_pos;
    int                wr_left;
    bit                eos;
    bit                rd_en    = 1'b1;
    bit                wr_en    = 1'b1;
    logic [SIZE_W-1:0] size_reg = 9'd256;

    stream_resp_t awaited_q [$];
    int           mismatch_count = 0;
    bit           gaps_on        = 1'b1;

    initial begin
        foreach (store_copy[i]) store_copy[i] = '0;
        rd_pos  = 0;
        rd_left = 0;
        wr_pos  = 0;
        wr_left = 0;
        eos     = 1'b0;
    end

    // size register as the block uses it: zero counts as one, capped at depth
    function automatic int used_size();
        int sz;
        sz = int'(size_reg);
        if (sz < 1) sz = 1;
        if (sz > DEPTH) sz = DEPTH;
        return sz;
    endfunction

    function automatic bit move_fits(int pos, int left, int off, int sz);
        return (pos + off >= 0) && (pos + off <= sz) &&
               (left - off >= 0) && (left - off <= sz);
    endfunction

    function automatic stream_resp_t stream_response(
        input logic [REQ_W-1:0]           kind,
        input logic [BYTE_W-1:0]          wdata,
        input logic [ORIGIN_W-1:0]        origin,
        input logic signed [OFFSET_W-1:0] offset
    );
        int           sz;
        int           off;
        stream_resp_t r;
        sz = used_size();
        off = int'(offset);
        r = '0;
        case (kind)
            REQ_PUT: begin
                if (wr_left == 0) begin
                    eos = 1'b1;
                    r.end_hit = 1'b1;
                end else begin
                    if (wr_pos < DEPTH) store_copy[wr_pos] = wdata;
                    wr_pos++;
                    wr_left--;
                    r.data = wdata;
                end
            end
            REQ_GET: begin
                if (rd_left == 0) begin
                    eos = 1'b1;
                    r.end_hit = 1'b1;
                end else begin
                    if (rd_pos < DEPTH) r.data = store_copy[rd_pos];
                    rd_pos++;
                    rd_left--;
                end
            end
            REQ_UNGET: begin
                if (rd_pos == 0) begin
                    r.move_refused = 1'b1;
                end else begin
                    if (rd_left == 0) eos = 1'b0;
                    rd_left++;
                    rd_pos--;
                end
            end
            default: begin
                // any seek clears the end flag, refused or not
                eos = 1'b0;
                case (origin)
                    ORG_START: begin
                        if (rd_en) begin
                            rd_pos  = 0;
                            rd_left = sz;
                        end
                        if (wr_en) begin
                            wr_pos  = 0;
                            wr_left = sz;
                        end
                    end
                    ORG_END: begin
                        if (rd_en) begin
                            rd_pos  = sz;
                            rd_left = 0;
                        end
                        if (wr_en) begin
                            wr_pos  = sz;
                            wr_left = 0;
                        end
                    end
                    ORG_REL: begin
                        // all enabled cursors move, or none
                        if ((rd_en && !move_fits(rd_pos, rd_left, off, sz)) ||
                            (wr_en && !move_fits(wr_pos, wr_left, off, sz))) begin
                            r.move_refused = 1'b1;
                        end else begin
                            if (rd_en) begin
                                rd_pos  += off;
                                rd_left -= off;
                            end
                            if (wr_en) begin
                                wr_pos  += off;
                                wr_left -= off;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        endcase
        r.end_flag = eos;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request driver, result stall and result checker
    // ------------------------------------------------------------------
    // one request: random gap, hold until taken, then predict its response
    task automatic send_req(
        input logic [REQ_W-1:0]    kind,
        input logic [BYTE_W-1:0]   wdata,
        input logic [ORIGIN_W-1:0] origin,
        input int                  offset
    );
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 27) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_req_type    = kind;
        i_put_byte    = wdata;
        i_seek_origin = origin;
        i_seek_offset = offset[OFFSET_W-1:0];
        i_valid       = 1'b1;
        do @(posedge i_clk); while (o_stall);
        awaited_q.push_back(stream_response(kind, wdata, origin, i_seek_offset));
    endtask

    // sender holds off until every predicted response has come back
    task automatic wait_for_responses();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (awaited_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = value[CFG_W-1:0];
        case (idx)
            CFG_READ_EN:  rd_en    = value[0];
            CFG_WRITE_EN: wr_en    = value[0];
            CFG_BUF_SIZE: size_reg = value[SIZE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_stream_config(input bit rd, input bit wr, input int sz);
        wait_for_responses();
        write_reg(CFG_READ_EN, int'(rd));
        write_reg(CFG_WRITE_EN, int'(wr));
        write_reg(CFG_BUF_SIZE, sz);
    endtask

    always @(negedge i_clk) i_stall = gaps_on && ($urandom_range(99) < 27);

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        stream_resp_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_q.size() == 0) begin
                mismatch_count++;
                $display({"%0t unexpected response: expected none, ",
                          "actual byte %0h hit %0b flag %0b refused %0b"},
                         $time, o_byte_out, o_end_hit, o_end_flag, o_move_refused);
            end else begin
                want = awaited_q.pop_front();
                check_field("byte_out", int'(want.data), int'(o_byte_out));
                check_field("end_hit", int'(want.end_hit), int'(o_end_hit));
                check_field("end_flag", int'(want.end_flag), int'(o_end_flag));
                check_field("move_refused", int'(want.move_refused), int'(o_move_refused));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // cursors have no room after reset until the first seek
    task automatic test_power_up();
        send_req(REQ_GET, 8'h00, ORG_START, 0);
        send_req(REQ_PUT, 8'h3C, ORG_END, 0);
        send_req(REQ_UNGET, 8'h00, ORG_REL, 0);
        send_req(REQ_SEEK, 8'h00, ORG_NONE, 5);
    endtask

    // fill a two byte buffer, run off its end, read back, step back
    task automatic test_put_get();
        set_stream_config(1'b1, 1'b1, 2);
        send_req(REQ_SEEK, 8'h00, ORG_START, -3);
        send_req(REQ_PUT, 8'h00, ORG_START, 0);
        send_req(REQ_PUT, 8'hFF, ORG_START, 0);
        send_req(REQ_PUT, 8'hA5, ORG_START, 0);
        send_req(REQ_SEEK, 8'h00, ORG_START, 0);
        send_req(REQ_GET, 8'h00, ORG_START, 0);
        send_req(REQ_GET, 8'h00, ORG_START, 0);
        send_req(REQ_GET, 8'h00, ORG_START, 0);
        send_req(REQ_UNGET, 8'h00, ORG_START, 0);
        send_req(REQ_GET, 8'h00, ORG_START, 0);
    endtask

    // offsets of +256 and -256, oversize and zero size, a single enabled cursor
    task automatic test_seek_limits();
        set_stream_config(1'b1, 1'b1, 511);
        send_req(REQ_SEEK, 8'h00, ORG_START, 0);
        send_req(REQ_SEEK, 8'h00, ORG_REL, 256);
        send_req(REQ_SEEK, 8'h00, ORG_REL, 1);
        send_req(REQ_SEEK, 8'h00, ORG_REL, -256);
        send_req(REQ_SEEK, 8'h00, ORG_END, 17);
        send_req(REQ_SEEK, 8'h00, ORG_NONE, -256);
        set_stream_config(1'b0, 1'b1, 0);
        send_req(REQ_SEEK, 8'h00, ORG_START, 0);
        send_req(REQ_SEEK, 8'h00, ORG_REL, -1);
        send_req(REQ_SEEK, 8'h00, ORG_REL, 1);
    endtask

    // random traffic over several settings; size -1 picks a random size
    task automatic test_random_traffic();
        bit phase_rd [10] = '{1, 1, 1, 0, 0, 1, 1, 1, 1, 1};
        bit phase_wr [10] = '{1, 1, 0, 1, 0, 1, 1, 1, 1, 1};
        int phase_sz [10] = '{256, 1, 8, 16, 5, -1, 2, 511, 0, -1};
        int sz;
        int pick;
        int offset;
        logic [REQ_W-1:0]    kind;
        logic [ORIGIN_W-1:0] origin;
        for (int p = 0; p < 10; p++) begin
            sz = (phase_sz[p] < 0) ? $urandom_range(1, 64) : phase_sz[p];
            set_stream_config(phase_rd[p], phase_wr[p], sz);
            sz = used_size();
            // one phase runs back to back with no gaps on either side
            gaps_on = (p != 3);
            for (int n = 0; n < 120; n++) begin
                if (p == 5 && n == 60) wait_for_responses();
                pick = $urandom_range(99);
                kind = (pick < 35) ? REQ_PUT : (pick < 65) ? REQ_GET :
                       (pick < 75) ? REQ_UNGET : REQ_SEEK;
                pick = $urandom_range(99);
                origin = (pick < 35) ? ORG_START : (pick < 45) ? ORG_END :
                         (pick < 95) ? ORG_REL : ORG_NONE;
                // mostly moves that can fit, some anywhere from -256 to 256
                if (kind == REQ_SEEK && origin == ORG_REL && $urandom_range(99) < 80)
                    offset = int'($urandom_range(2 * sz)) - sz;
                else
                    offset = int'($urandom_range(512)) - 256;
                send_req(kind, BYTE_W'($urandom_range(255)), origin, offset);
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_power_up();
        test_put_get();
        test_seek_limits();
        test_random_traffic();
        wait_for_responses();
        repeat (4) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("[byte_stream_buffer_cursors] OK");
        else
            $display("[byte_stream_buffer_cursors] ERROR");
        $finish;
    end

    // run limit, well beyond the clearing pass plus all traffic
    initial begin
        #200000;
        $display("[byte_stream_buffer_cursors] ERROR");
        $finish;
    end

endmodule
